// File: sv/rgbsh_pkg.sv
// Shared types and constants for the RGB 3x3 sharpening stencil.
package rgbsh_pkg;

  // Fixed field widths of the streaming and register interfaces
  localparam int PIX_IN_BITS = 8;
  localparam int OUT_BITS    = 12;
  localparam int CFG_BITS    = 11;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam int NUM_CH      = 3;

  // Frame size after reset
  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd512;

  // Input beat kinds carried on cmd
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Register map, selected by paddr[2]
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Which neighbor taps fall outside the frame for the current result
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } border_t;

  // One result beat
  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
    logic                frame_end;
  } pix_res_t;

endpackage

// File: sv/rgb_sharpen_3x3_stencil.sv
// Top level: 3x3 sharpening stencil over an RGB raster stream, three color lanes.
// Throughput: one item per cycle; in_stall rises only when output and skid slots are both full.
// Order: a result leaves one row plus one pixel after its center pixel; it is registered into
//   the output slot, or the skid slot if output is held, as the completing item is accepted.
// Reset (synchronous, rst_n low): counters and window clear, size registers return to 512;
//   line buffer RAM keeps undefined contents, no clearing pass.
module rgb_sharpen_3x3_stencil #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_HEIGHT   = 1024,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rgbsh_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [rgbsh_pkg::DATA_BITS-1:0]       pwdata,
  output logic [rgbsh_pkg::DATA_BITS-1:0]       prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [rgbsh_pkg::PIX_IN_BITS-1:0]     in_red_in,
  input  logic [rgbsh_pkg::PIX_IN_BITS-1:0]     in_green_in,
  input  logic [rgbsh_pkg::PIX_IN_BITS-1:0]     in_blue_in,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rgbsh_pkg::OUT_BITS-1:0] out_red_out,
  output logic signed [rgbsh_pkg::OUT_BITS-1:0] out_green_out,
  output logic signed [rgbsh_pkg::OUT_BITS-1:0] out_blue_out,
  output logic                                  out_frame_end
);
  import rgbsh_pkg::*;

  localparam int CB  = CHANNEL_BITS;
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int EWW = (CW > CFG_BITS) ? CW : CFG_BITS;
  localparam int EHW = (RW > CFG_BITS) ? RW : CFG_BITS;
  localparam int XW  = (CB > PIX_IN_BITS) ? CB : PIX_IN_BITS;
  localparam int LW  = NUM_CH * CB;

  // Effective sizes: zero counts as one, large values saturate
  function automatic logic [CW-1:0] eff_w_f(input logic [CFG_BITS-1:0] v);
    logic [EWW-1:0] ve;
    ve = EWW'(v);
    if (ve == '0) return CW'(1);
    else if (ve > EWW'(MAX_WIDTH)) return CW'(MAX_WIDTH);
    else return CW'(ve);
  endfunction

  function automatic logic [RW-1:0] eff_h_f(input logic [CFG_BITS-1:0] v);
    logic [EHW-1:0] ve;
    ve = EHW'(v);
    if (ve == '0) return RW'(1);
    else if (ve > EHW'(MAX_HEIGHT)) return RW'(MAX_HEIGHT);
    else return RW'(ve);
  endfunction

  // ---------------- register port ----------------
  logic [CFG_BITS-1:0] width_r, height_r;
  logic [CW-1:0]       eff_w_r;
  logic [RW-1:0]       eff_h_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_RESET;
      height_r <= CFG_RESET;
      eff_w_r  <= eff_w_f(CFG_RESET);
      eff_h_r  <= eff_h_f(CFG_RESET);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH: begin
          width_r <= pwdata[CFG_BITS-1:0];
          eff_w_r <= eff_w_f(pwdata[CFG_BITS-1:0]);
        end
        REG_HEIGHT: begin
          height_r <= pwdata[CFG_BITS-1:0];
          eff_h_r  <= eff_h_f(pwdata[CFG_BITS-1:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = DATA_BITS'(width_r);
      REG_HEIGHT: prdata = DATA_BITS'(height_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------- item control ----------------
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic          take, frame_in, proceed, active, produce;
  logic          merge_full;
  border_t       border;

  assign in_stall = merge_full;
  assign take     = in_valid && !in_stall;
  assign frame_in = in_row_r < eff_h_r;
  // drain beats before the frame is complete change nothing
  assign proceed  = take && !(in_cmd == CMD_DRAIN && frame_in);
  assign active   = (in_row_r >= RW'(2)) || (in_row_r == RW'(1) && in_col_r != '0);
  assign produce  = proceed && active;

  assign border.top   = out_row_r == '0;
  assign border.bot   = out_row_r >= eff_h_r - RW'(1);
  assign border.left  = out_col_r == '0;
  assign border.right = out_col_r >= eff_w_r - CW'(1);

  // Raster counters for the input and result positions
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (proceed) begin
      if (in_col_r >= eff_w_r - CW'(1)) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
    if (produce) begin
      if (border.right) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + RW'(1);
        // last result of the frame: restart everything
        if (border.bot) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end else begin
        out_col_nxt = out_col_r + CW'(1);
      end
    end
    if (cfg_wr) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------- line buffers ----------------
  // One RAM word per column: {row above, current row}, all three channels each
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [2*LW-1:0] ram_q, wdata, rd_data, fwd_r;
  logic            hit_r;
  logic [LW-1:0]   pix_all;

  // Read one item ahead at the next column
  assign rd_addr = rst_n ? in_col_nxt[AW-1:0] : '0;
  assign wr_addr = in_col_r[AW-1:0];
  assign wdata   = {rd_data[LW-1:0], pix_all};

  rgbsh_ram #(
    .WIDTH (2 * LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (proceed),
    .waddr (wr_addr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Forward a write to the same column (one-pixel-wide frames)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= proceed && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_r <= wdata;
  end

  assign rd_data = hit_r ? fwd_r : ram_q;

  // ---------------- color lanes ----------------
  logic [XW-1:0]       ext   [NUM_CH];
  logic [OUT_BITS-1:0] lane_res [NUM_CH];

  assign ext[0] = XW'(in_red_in);
  assign ext[1] = XW'(in_green_in);
  assign ext[2] = XW'(in_blue_in);

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    // pixels past the end of the frame enter as zero
    assign pix_all[k*CB +: CB] = (frame_in && in_cmd == CMD_PIXEL) ? ext[k][CB-1:0] : '0;

    rgbsh_lane #(
      .CB (CB)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .shift  (proceed),
      .above  (rd_data[LW + k*CB +: CB]),
      .cur    (rd_data[k*CB +: CB]),
      .pix    (pix_all[k*CB +: CB]),
      .border (border),
      .res    (lane_res[k])
    );
  end

  // ---------------- merge and output ----------------
  pix_res_t push_data, out_data;

  assign push_data.red       = lane_res[0];
  assign push_data.green     = lane_res[1];
  assign push_data.blue      = lane_res[2];
  assign push_data.frame_end = border.bot && border.right;

  rgbsh_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (produce),
    .push_data (push_data),
    .full      (merge_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_red_out   = $signed(out_data.red);
  assign out_green_out = $signed(out_data.green);
  assign out_blue_out  = $signed(out_data.blue);
  assign out_frame_end = out_data.frame_end;

`ifndef SYNTH
  // Input column always inside the configured row
  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r < eff_w_r)
    else $error("input column beyond row width");

  // Result column always inside the configured row
  a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_col_r < eff_w_r)
    else $error("result column beyond row width");

  // A register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("counters not cleared by register write");
`endif

endmodule

// File: sv/rgbsh_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
module rgbsh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/rgbsh_lane.sv
// One color lane: the window taps of a channel and its 5C - N - S - W - E kernel.
module rgbsh_lane #(
  parameter int CB = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift,
  input  logic [CB-1:0]                 above,
  input  logic [CB-1:0]                 cur,
  input  logic [CB-1:0]                 pix,
  input  rgbsh_pkg::border_t            border,
  output logic [rgbsh_pkg::OUT_BITS-1:0] res
);
  import rgbsh_pkg::*;

  // Sum width: wide enough for the full kernel, never narrower than the output
  localparam int EW = (CB + 4 > OUT_BITS) ? CB + 4 : OUT_BITS;

  // Window taps that the kernel reads: center row's west and center, and the
  // center column's north (line buffers) and south (input pixel)
  logic [CB-1:0] lf_r, c_r, up_r, dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lf_r <= '0;
      c_r  <= '0;
      up_r <= '0;
      dn_r <= '0;
    end else if (shift) begin
      lf_r <= c_r;
      c_r  <= cur;
      up_r <= above;
      dn_r <= pix;
    end
  end

  // Border taps repeat the center pixel
  logic [CB-1:0] t_up, t_dn, t_lf, t_rt;
  assign t_up = border.top   ? c_r : up_r;
  assign t_dn = border.bot   ? c_r : dn_r;
  assign t_lf = border.left  ? c_r : lf_r;
  assign t_rt = border.right ? c_r : cur;

  // Kernel, modulo 2^EW; the low bits are the two's complement result
  logic [EW-1:0] c5, sum;
  assign c5  = (EW'(c_r) << 2) + EW'(c_r);
  assign sum = c5 - EW'(t_up) - EW'(t_dn) - EW'(t_lf) - EW'(t_rt);
  assign res = sum[OUT_BITS-1:0];

endmodule

// File: sv/rgbsh_merge.sv
// Holds result beats, built from the lane results by the top level, in an output register plus skid slot.
module rgbsh_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rgbsh_pkg::pix_res_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output rgbsh_pkg::pix_res_t out_data
);
  import rgbsh_pkg::*;

  logic     ov_r, ov_nxt;
  logic     sv_r, sv_nxt;
  pix_res_t od_r, od_nxt;
  pix_res_t sd_r, sd_nxt;
  logic     pop;

  assign pop = ov_r && !out_stall;

  // Output slot refills from the skid first, then from the lanes
  always_comb begin
    ov_nxt = ov_r;
    sv_nxt = sv_r;
    od_nxt = od_r;
    sd_nxt = sd_r;
    if (sv_r) begin
      if (pop) begin
        od_nxt = sd_r;
        sv_nxt = 1'b0;
      end
    end else if (push) begin
      if (!ov_r || pop) begin
        od_nxt = push_data;
        ov_nxt = 1'b1;
      end else begin
        sd_nxt = push_data;
        sv_nxt = 1'b1;
      end
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    sd_r <= sd_nxt;
  end

  assign full      = sv_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

`ifndef SYNTH
  // Skid slot only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid slot valid with empty output slot");

  // A beat arriving at a stalled output must land in the skid slot
  a_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !sv_r && ov_r && out_stall) |=> sv_r)
    else $error("beat lost while output stalled");
`endif

endmodule
